// ----- hdl/vvpr_pkg.sv -----
package vvpr_pkg;

   // voice file size
   localparam int VOICE_COUNT = 8;
   localparam int IDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int CNT_W       = $clog2(VOICE_COUNT + 1);

   // field widths
   localparam int CMD_W     = 2;
   localparam int VOICE_W   = 3;
   localparam int MODE_W    = 3;
   localparam int SOUND_W   = 16;
   localparam int VAL_W     = 8;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DW    = 24;
   localparam int RSP_DW    = 40;

   // request commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MODE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SOUND = 2'd2;

   // placement modes
   localparam logic [MODE_W-1:0] MODE_OTHER  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GONE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CENTER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MUTE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MARK   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_STEP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAN_STEP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_VOLUME = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_VOLUME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_PAN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_PAN      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_PAN     = 3'd6;

   // register reset values
   localparam logic [VAL_W-1:0] RST_VOLUME_STEP   = 8'd8;
   localparam logic [VAL_W-1:0] RST_PAN_STEP      = 8'd2;
   localparam logic [VAL_W-1:0] RST_CENTER_VOLUME = 8'hff;
   localparam logic [VAL_W-1:0] RST_SIDE_VOLUME   = 8'd100;
   localparam logic [VAL_W-1:0] RST_CENTER_PAN    = 8'h80;
   localparam logic [VAL_W-1:0] RST_LEFT_PAN      = 8'h3c;
   localparam logic [VAL_W-1:0] RST_RIGHT_PAN     = 8'hc3;

   // controller to datapath
   typedef struct packed {
      logic             set_mode;
      logic             set_sound;
      logic             commit;
      logic             load_upd;
      logic             load_mute;
      logic             load_mark;
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic moved;
      logic has_sound;
      logic mute;
      logic out_free;
   } dp_stat_type;

endpackage

// ----- hdl/vvpr_ctrl.sv -----
module vvpr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [vvpr_pkg::CMD_W-1:0] req_command,
   input  vvpr_pkg::dp_stat_type    stat,
   output vvpr_pkg::dp_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_MUTE = 3'd3;
   localparam logic [2:0] ST_MARK = 3'd4;

   localparam logic [vvpr_pkg::CNT_W-1:0] CNT_END = vvpr_pkg::CNT_W'(vvpr_pkg::VOICE_COUNT);

   logic [2:0]                 state_ff, state_in;
   logic [vvpr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       mute_pend_ff, mute_pend_in;
   logic                       req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mute_pend_in = mute_pend_ff;
      cmd          = '0;
      cmd.idx      = cnt_ff[vvpr_pkg::IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_command)
                  vvpr_pkg::CMD_TICK: begin
                     cnt_in   = '0;
                     state_in = ST_EVAL;
                  end
                  vvpr_pkg::CMD_MODE:  cmd.set_mode  = 1'b1;
                  vvpr_pkg::CMD_SOUND: cmd.set_sound = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_EVAL: begin
            if (cnt_ff == CNT_END || !stat.moved) begin
               state_in = ST_MARK;
            end else begin
               cmd.commit   = 1'b1;
               mute_pend_in = stat.mute;
               if (stat.has_sound && !stat.out_free) begin
                  state_in = ST_UPD;
               end else begin
                  cmd.load_upd = stat.has_sound;
                  if (stat.mute) begin
                     state_in = ST_MUTE;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
         end
         ST_UPD: begin
            if (stat.out_free) begin
               cmd.load_upd = 1'b1;
               if (mute_pend_ff) begin
                  state_in = ST_MUTE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_EVAL;
               end
            end
         end
         ST_MUTE: begin
            if (stat.out_free) begin
               cmd.load_mute = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_MARK: begin
            if (stat.out_free) begin
               cmd.load_mark = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mute_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mute_pend_ff <= mute_pend_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_END)
      else $error("voice counter beyond voice count");

   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_command == vvpr_pkg::CMD_TICK) |=> (state_ff == ST_EVAL && cnt_ff == '0))
      else $error("tick did not start scan at voice zero");

   a_mute_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUTE) |-> mute_pend_ff)
      else $error("mute state without pending mute");

endmodule

// ----- hdl/vvpr_dpath.sv -----
module vvpr_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [vvpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vvpr_pkg::VAL_W-1:0]         csr_wdata,
   input  logic [vvpr_pkg::VOICE_W-1:0]       req_voice,
   input  logic [vvpr_pkg::MODE_W-1:0]        req_placement,
   input  logic [vvpr_pkg::SOUND_W-1:0]       req_sound,
   input  vvpr_pkg::dp_cmd_type               cmd,
   output vvpr_pkg::dp_stat_type              stat,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [vvpr_pkg::RSP_DW-1:0]        rsp_tdata,
   output logic [vvpr_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int VC = vvpr_pkg::VOICE_COUNT;
   localparam int VW = vvpr_pkg::VAL_W;

   typedef struct packed {
      logic [VW-1:0] val;
      logic          moved;
   } step_type;

   // one step toward target; snaps when strictly inside one step of it
   function automatic step_type step_toward(input logic [VW-1:0] cur,
                                            input logic [VW-1:0] tgt,
                                            input logic [VW-1:0] step);
      step_type          r;
      logic signed [9:0] s, sum, diff;
      s        = signed'({2'b00, step});
      r.val    = cur;
      r.moved  = 1'b0;
      if (cur != tgt) begin
         r.moved = 1'b1;
         if (cur < tgt) sum = signed'({2'b00, cur}) + s;
         else           sum = signed'({2'b00, cur}) - s;
         diff = sum - signed'({2'b00, tgt});
         if (diff < s && diff > -s) r.val = tgt;
         else                       r.val = sum[VW-1:0];
      end
      return r;
   endfunction

   // configuration
   logic [VW-1:0] vol_step_ff, pan_step_ff, ctr_vol_ff, side_vol_ff;
   logic [VW-1:0] ctr_pan_ff, left_pan_ff, right_pan_ff;
   logic [VW-1:0] vol_step_in, pan_step_in, ctr_vol_in, side_vol_in;
   logic [VW-1:0] ctr_pan_in, left_pan_in, right_pan_in;

   // voice file
   logic [vvpr_pkg::MODE_W-1:0]  mode_ff [VC];
   logic [vvpr_pkg::MODE_W-1:0]  mode_in [VC];
   logic [VW-1:0]                vol_ff  [VC];
   logic [VW-1:0]                vol_in  [VC];
   logic [VW-1:0]                pan_ff  [VC];
   logic [VW-1:0]                pan_in  [VC];
   logic [vvpr_pkg::SOUND_W-1:0] snd_ff  [VC];
   logic [vvpr_pkg::SOUND_W-1:0] snd_in  [VC];

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vvpr_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [vvpr_pkg::VOICE_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [vvpr_pkg::SOUND_W-1:0]  rsp_snd_ff, rsp_snd_in;
   logic [VW-1:0]                 rsp_lvl_ff, rsp_lvl_in;
   logic [VW-1:0]                 rsp_bal_ff, rsp_bal_in;

   logic [vvpr_pkg::MODE_W-1:0] cur_mode;
   logic [VW-1:0]               tgt_vol, tgt_pan;
   step_type                    vstep, pstep;
   logic                        set_ok;
   logic [vvpr_pkg::IDX_W-1:0]  set_idx;
   logic                        out_free;

   assign cur_mode = mode_ff[cmd.idx];
   assign set_ok   = (int'(req_voice) < VC);
   assign set_idx  = vvpr_pkg::IDX_W'(req_voice);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (cur_mode)
         vvpr_pkg::MODE_CENTER: begin
            tgt_vol = ctr_vol_ff;
            tgt_pan = ctr_pan_ff;
         end
         vvpr_pkg::MODE_LEFT: begin
            tgt_vol = side_vol_ff;
            tgt_pan = left_pan_ff;
         end
         vvpr_pkg::MODE_RIGHT: begin
            tgt_vol = side_vol_ff;
            tgt_pan = right_pan_ff;
         end
         default: begin
            tgt_vol = '0;
            tgt_pan = pan_ff[cmd.idx];
         end
      endcase
      vstep = step_toward(vol_ff[cmd.idx], tgt_vol, vol_step_ff);
      pstep = step_toward(pan_ff[cmd.idx], tgt_pan, pan_step_ff);
   end

   assign stat.moved     = vstep.moved || pstep.moved;
   assign stat.has_sound = (snd_ff[cmd.idx] != '0);
   assign stat.mute      = (vstep.val == tgt_vol) && (pstep.val == tgt_pan)
                           && (cur_mode == vvpr_pkg::MODE_GONE);
   assign stat.out_free  = out_free;

   always_comb begin
      vol_step_in  = vol_step_ff;
      pan_step_in  = pan_step_ff;
      ctr_vol_in   = ctr_vol_ff;
      side_vol_in  = side_vol_ff;
      ctr_pan_in   = ctr_pan_ff;
      left_pan_in  = left_pan_ff;
      right_pan_in = right_pan_ff;
      if (csr_we) begin
         unique case (csr_index)
            vvpr_pkg::CSR_VOLUME_STEP:   vol_step_in  = csr_wdata;
            vvpr_pkg::CSR_PAN_STEP:      pan_step_in  = csr_wdata;
            vvpr_pkg::CSR_CENTER_VOLUME: ctr_vol_in   = csr_wdata;
            vvpr_pkg::CSR_SIDE_VOLUME:   side_vol_in  = csr_wdata;
            vvpr_pkg::CSR_CENTER_PAN:    ctr_pan_in   = csr_wdata;
            vvpr_pkg::CSR_LEFT_PAN:      left_pan_in  = csr_wdata;
            vvpr_pkg::CSR_RIGHT_PAN:     right_pan_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in = mode_ff;
      vol_in  = vol_ff;
      pan_in  = pan_ff;
      snd_in  = snd_ff;
      if (cmd.set_mode && set_ok)  mode_in[set_idx] = req_placement;
      if (cmd.set_sound && set_ok) snd_in[set_idx]  = req_sound;
      if (cmd.commit) begin
         vol_in[cmd.idx] = vstep.val;
         pan_in[cmd.idx] = pstep.val;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_snd_in   = rsp_snd_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_bal_in   = rsp_bal_ff;
      if (cmd.load_upd || cmd.load_mute || cmd.load_mark) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = vvpr_pkg::VOICE_W'(cmd.idx);
         rsp_snd_in   = '0;
         rsp_lvl_in   = '0;
         rsp_bal_in   = '0;
      end
      if (cmd.load_upd) begin
         rsp_kind_in = vvpr_pkg::KIND_UPDATE;
         rsp_snd_in  = snd_ff[cmd.idx];
         // same-cycle update uses fresh values, later ones the stored voice
         rsp_lvl_in  = cmd.commit ? vstep.val : vol_ff[cmd.idx];
         rsp_bal_in  = cmd.commit ? pstep.val : pan_ff[cmd.idx];
      end
      if (cmd.load_mute) rsp_kind_in = vvpr_pkg::KIND_MUTE;
      if (cmd.load_mark) begin
         rsp_kind_in = vvpr_pkg::KIND_MARK;
         rsp_idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_step_ff  <= vvpr_pkg::RST_VOLUME_STEP;
         pan_step_ff  <= vvpr_pkg::RST_PAN_STEP;
         ctr_vol_ff   <= vvpr_pkg::RST_CENTER_VOLUME;
         side_vol_ff  <= vvpr_pkg::RST_SIDE_VOLUME;
         ctr_pan_ff   <= vvpr_pkg::RST_CENTER_PAN;
         left_pan_ff  <= vvpr_pkg::RST_LEFT_PAN;
         right_pan_ff <= vvpr_pkg::RST_RIGHT_PAN;
         for (int i = 0; i < VC; i++) begin
            mode_ff[i] <= vvpr_pkg::MODE_OTHER;
            vol_ff[i]  <= '0;
            pan_ff[i]  <= '0;
            snd_ff[i]  <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         vol_step_ff  <= vol_step_in;
         pan_step_ff  <= pan_step_in;
         ctr_vol_ff   <= ctr_vol_in;
         side_vol_ff  <= side_vol_in;
         ctr_pan_ff   <= ctr_pan_in;
         left_pan_ff  <= left_pan_in;
         right_pan_ff <= right_pan_in;
         mode_ff      <= mode_in;
         vol_ff       <= vol_in;
         pan_ff       <= pan_in;
         snd_ff       <= snd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_snd_ff  <= rsp_snd_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_bal_ff  <= rsp_bal_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_bal_ff, rsp_lvl_ff, rsp_snd_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = (rsp_kind_ff == vvpr_pkg::KIND_MARK);

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_upd || cmd.load_mute || cmd.load_mark) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while still held");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_upd, cmd.load_mute, cmd.load_mark}))
      else $error("more than one result load in a cycle");

   a_mute_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == vvpr_pkg::KIND_MUTE)
         |-> (rsp_snd_ff == '0 && rsp_lvl_ff == '0 && rsp_bal_ff == '0))
      else $error("mute result carries payload");

endmodule

// ----- hdl/voice_volume_pan_ramper.sv -----
// Voice volume and pan ramper for eight voices. Each voice holds a placement
// mode, a sound id, a volume and a pan. A request with tuser 1 sets a voice's
// mode, tuser 2 its sound id; both are applied without giving any result, and a
// voice index beyond the voice file is dropped. A request with tuser 0 is a
// tick: voices are visited in order, each volume and pan stepping one
// configured amount toward the target given by its mode (snapping onto it when
// inside one step). A voice that moved gives an update if its sound id is
// nonzero, and a gone voice that has arrived then gives a mute. The scan stops
// at the first voice that did not move, and every tick ends with a marker that
// has tlast set. While the result register is free and no mute is pending,
// the scan evaluates one voice per cycle through a single shared stepping
// unit; mutes take a slot of their own in the result register, and
// back-pressure on rsp stalls the scan. New requests are taken only between
// ticks. Configuration writes are registered and belong to idle periods only.
module voice_volume_pan_ramper (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_we,
   input  logic [vvpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vvpr_pkg::VAL_W-1:0]          csr_wdata,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vvpr_pkg::REQ_DW-1:0]         req_tdata,  // voice, placement, new_sound_id
   input  logic [vvpr_pkg::CMD_W-1:0]          req_tuser,  // command
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vvpr_pkg::RSP_DW-1:0]         rsp_tdata,  // voice_index, sound_id, level, balance
   output logic [vvpr_pkg::KIND_W-1:0]         rsp_tuser,  // kind
   output logic                                rsp_tlast   // last
);

   vvpr_pkg::dp_cmd_type  cmd;
   vvpr_pkg::dp_stat_type stat;

   // request fields, lowest first
   logic [vvpr_pkg::VOICE_W-1:0] req_voice;
   logic [vvpr_pkg::MODE_W-1:0]  req_placement;
   logic [vvpr_pkg::SOUND_W-1:0] req_sound;

   assign req_voice     = req_tdata[2:0];
   assign req_placement = req_tdata[5:3];
   assign req_sound     = req_tdata[21:6];

   // sequencer: request decode, voice scan, result ordering
   vvpr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .stat        (stat),
      .cmd         (cmd)
   );

   // registers, voice file, stepping unit and result register
   vvpr_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_voice     (req_voice),
      .req_placement (req_placement),
      .req_sound     (req_sound),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

// ----- test/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // command code the block must ignore
   localparam logic [vvpr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int          REG_COUNT       = 7;
   localparam int          SEGMENT_ITEMS   = 60;
   localparam int          SETTLE_CYCLES   = 24;   // covers a set request still in flight
   localparam int          RSP_HOLD_CYCLES = 300;  // long enough to back the block up
   localparam int unsigned CYCLE_LIMIT     = 400000;

   // one result as the checker sees it
   typedef struct {
      logic [vvpr_pkg::KIND_W-1:0]  kind;
      logic [vvpr_pkg::VOICE_W-1:0] voice;
      logic [vvpr_pkg::SOUND_W-1:0] sound;
      logic [vvpr_pkg::VAL_W-1:0]   level;
      logic [vvpr_pkg::VAL_W-1:0]   balance;
      logic                         last;
   } ramp_result_type;

   // Mirror of the voice file plus the queue of results still owed by the block.
   class ramp_scoreboard;
      logic [vvpr_pkg::VAL_W-1:0]   regs        [REG_COUNT];
      logic [vvpr_pkg::MODE_W-1:0]  voice_mode  [vvpr_pkg::VOICE_COUNT];
      logic [vvpr_pkg::VAL_W-1:0]   voice_level [vvpr_pkg::VOICE_COUNT];
      logic [vvpr_pkg::VAL_W-1:0]   voice_pan   [vvpr_pkg::VOICE_COUNT];
      logic [vvpr_pkg::SOUND_W-1:0] voice_sound [vvpr_pkg::VOICE_COUNT];
      ramp_result_type              pending_results[$];
      int                           failures;

      function new();
         regs[vvpr_pkg::CSR_VOLUME_STEP]   = vvpr_pkg::RST_VOLUME_STEP;
         regs[vvpr_pkg::CSR_PAN_STEP]      = vvpr_pkg::RST_PAN_STEP;
         regs[vvpr_pkg::CSR_CENTER_VOLUME] = vvpr_pkg::RST_CENTER_VOLUME;
         regs[vvpr_pkg::CSR_SIDE_VOLUME]   = vvpr_pkg::RST_SIDE_VOLUME;
         regs[vvpr_pkg::CSR_CENTER_PAN]    = vvpr_pkg::RST_CENTER_PAN;
         regs[vvpr_pkg::CSR_LEFT_PAN]      = vvpr_pkg::RST_LEFT_PAN;
         regs[vvpr_pkg::CSR_RIGHT_PAN]     = vvpr_pkg::RST_RIGHT_PAN;
         for (int i = 0; i < vvpr_pkg::VOICE_COUNT; i++) begin
            voice_mode[i]  = vvpr_pkg::MODE_OTHER;
            voice_level[i] = '0;
            voice_pan[i]   = '0;
            voice_sound[i] = '0;
         end
         failures = 0;
      endfunction

      function void set_reg(logic [vvpr_pkg::CSR_IDX_W-1:0] idx,
                            logic [vvpr_pkg::VAL_W-1:0] value);
         regs[idx] = value;
      endfunction

      // one step toward the target, snapping when left strictly inside a step
      function logic [vvpr_pkg::VAL_W-1:0] step_toward(logic [vvpr_pkg::VAL_W-1:0] value,
                                                       logic [vvpr_pkg::VAL_W-1:0] target,
                                                       logic [vvpr_pkg::VAL_W-1:0] amount);
         int c;
         int t;
         int s;
         c = value;
         t = target;
         s = amount;
         if (c == t) return value;
         c = (c < t) ? c + s : c - s;
         if ((c - t) < s && (c - t) > -s) c = t;
         return c[vvpr_pkg::VAL_W-1:0];
      endfunction

      function void push_result(logic [vvpr_pkg::KIND_W-1:0] kind, int voice,
                                logic [vvpr_pkg::SOUND_W-1:0] sound,
                                logic [vvpr_pkg::VAL_W-1:0] level,
                                logic [vvpr_pkg::VAL_W-1:0] balance, logic last);
         ramp_result_type r;
         r.kind    = kind;
         r.voice   = voice[vvpr_pkg::VOICE_W-1:0];
         r.sound   = sound;
         r.level   = level;
         r.balance = balance;
         r.last    = last;
         pending_results.push_back(r);
      endfunction

      function void note_request(logic [vvpr_pkg::CMD_W-1:0] cmd,
                                 logic [vvpr_pkg::VOICE_W-1:0] voice,
                                 logic [vvpr_pkg::MODE_W-1:0] placement,
                                 logic [vvpr_pkg::SOUND_W-1:0] sound);
         logic [vvpr_pkg::MODE_W-1:0] mode;
         logic [vvpr_pkg::VAL_W-1:0]  tgt_level;
         logic [vvpr_pkg::VAL_W-1:0]  tgt_pan;
         logic [vvpr_pkg::VAL_W-1:0]  nxt_level;
         logic [vvpr_pkg::VAL_W-1:0]  nxt_pan;
         case (cmd)
            vvpr_pkg::CMD_MODE: begin
               if (voice < vvpr_pkg::VOICE_COUNT) voice_mode[voice] = placement;
            end
            vvpr_pkg::CMD_SOUND: begin
               if (voice < vvpr_pkg::VOICE_COUNT) voice_sound[voice] = sound;
            end
            vvpr_pkg::CMD_TICK: begin
               for (int i = 0; i < vvpr_pkg::VOICE_COUNT; i++) begin
                  mode = voice_mode[i];
                  case (mode)
                     vvpr_pkg::MODE_CENTER: begin
                        tgt_level = regs[vvpr_pkg::CSR_CENTER_VOLUME];
                        tgt_pan   = regs[vvpr_pkg::CSR_CENTER_PAN];
                     end
                     vvpr_pkg::MODE_LEFT: begin
                        tgt_level = regs[vvpr_pkg::CSR_SIDE_VOLUME];
                        tgt_pan   = regs[vvpr_pkg::CSR_LEFT_PAN];
                     end
                     vvpr_pkg::MODE_RIGHT: begin
                        tgt_level = regs[vvpr_pkg::CSR_SIDE_VOLUME];
                        tgt_pan   = regs[vvpr_pkg::CSR_RIGHT_PAN];
                     end
                     default: begin
                        tgt_level = '0;
                        tgt_pan   = voice_pan[i];
                     end
                  endcase
                  // scan ends at the first settled voice
                  if (voice_level[i] == tgt_level && voice_pan[i] == tgt_pan) break;
                  nxt_level = step_toward(voice_level[i], tgt_level,
                                          regs[vvpr_pkg::CSR_VOLUME_STEP]);
                  nxt_pan   = step_toward(voice_pan[i], tgt_pan,
                                          regs[vvpr_pkg::CSR_PAN_STEP]);
                  voice_level[i] = nxt_level;
                  voice_pan[i]   = nxt_pan;
                  if (voice_sound[i] != '0)
                     push_result(vvpr_pkg::KIND_UPDATE, i, voice_sound[i], nxt_level,
                                 nxt_pan, 1'b0);
                  if (nxt_level == tgt_level && nxt_pan == tgt_pan
                      && mode == vvpr_pkg::MODE_GONE)
                     push_result(vvpr_pkg::KIND_MUTE, i, '0, '0, '0, 1'b0);
               end
               push_result(vvpr_pkg::KIND_MARK, 0, '0, '0, '0, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(ramp_result_type got);
         ramp_result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d voice %0d", got.kind, got.voice);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("kind",        want.kind,    got.kind);
         compare_field("voice_index", want.voice,   got.voice);
         compare_field("sound_id",    want.sound,   got.sound);
         compare_field("level",       want.level,   got.level);
         compare_field("balance",     want.balance, got.balance);
         compare_field("last",        want.last,    got.last);
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // clock, reset and block ports; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [vvpr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [vvpr_pkg::VAL_W-1:0]     csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [vvpr_pkg::REQ_DW-1:0]    req_tdata = '0;
   logic [vvpr_pkg::CMD_W-1:0]     req_tuser = vvpr_pkg::CMD_TICK;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [vvpr_pkg::RSP_DW-1:0]    rsp_tdata;
   logic [vvpr_pkg::KIND_W-1:0]    rsp_tuser;
   logic                           rsp_tlast;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   voice_volume_pan_ramper uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // voice [2:0], placement [5:3], new_sound_id [21:6]
      .req_tuser  (req_tuser),   // command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // voice_index [2:0], sound_id [18:3], level [26:19],
                                 // balance [34:27]
      .rsp_tuser  (rsp_tuser),   // kind
      .rsp_tlast  (rsp_tlast)    // last
   );

   ramp_scoreboard sb = new();

   int          req_idle_pct = 9;   // chance per request of a sender gap
   int          rsp_idle_pct = 56;  // chance per cycle of the receiver stalling
   logic        hold_kick = 1'b0;   // pulse: receiver starts a long hold-off
   int          hold_left = 0;
   int unsigned cycle_count = 0;

   // Receiver: random stalls, or a long hold-off counted down here while the
   // sender keeps offering requests, so the block backs up into req_tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_kick) begin
         rsp_tready <= 1'b0;
         hold_left  <= RSP_HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Result monitor: values sampled at the edge, before this edge's updates.
   always @(posedge clock) begin
      ramp_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind    = rsp_tuser;
         got.voice   = rsp_tdata[2:0];
         got.sound   = rsp_tdata[18:3];
         got.level   = rsp_tdata[26:19];
         got.balance = rsp_tdata[34:27];
         got.last    = rsp_tlast;
         sb.check_result(got);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // Offer one request; it is noted in the scoreboard at the accepting edge.
   // tvalid is left high so back-to-back requests never drop it mid-step.
   task automatic offer_request(logic [vvpr_pkg::CMD_W-1:0] cmd,
                                logic [vvpr_pkg::VOICE_W-1:0] voice,
                                logic [vvpr_pkg::MODE_W-1:0] placement,
                                logic [vvpr_pkg::SOUND_W-1:0] sound);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, sound, placement, voice};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, voice, placement, sound);
   endtask

   // Sender goes quiet until every owed result is in, then lets a set
   // request that gave nothing back finish before any register write.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all seven registers, one per edge, then drops the enable.
   task automatic load_settings(logic [vvpr_pkg::VAL_W-1:0] vals [REG_COUNT]);
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[vvpr_pkg::CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(i[vvpr_pkg::CSR_IDX_W-1:0], vals[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic: mostly ticks and set requests that keep voices ramping,
   // a little noise: undefined placements and the ignored command code.
   task automatic random_requests(int count);
      int                           pick;
      logic [vvpr_pkg::CMD_W-1:0]   cmd;
      logic [vvpr_pkg::MODE_W-1:0]  placement;
      logic [vvpr_pkg::SOUND_W-1:0] sound;
      logic [vvpr_pkg::VOICE_W-1:0] voice;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45)      cmd = vvpr_pkg::CMD_TICK;
         else if (pick < 72) cmd = vvpr_pkg::CMD_MODE;
         else if (pick < 95) cmd = vvpr_pkg::CMD_SOUND;
         else                cmd = CMD_UNUSED;
         // undefined placements now and then, otherwise a real mode
         if ($urandom_range(9) == 0)
            placement = vvpr_pkg::MODE_W'($urandom_range(7, vvpr_pkg::MODE_RIGHT + 1));
         else
            placement = vvpr_pkg::MODE_W'($urandom_range(vvpr_pkg::MODE_RIGHT));
         pick = $urandom_range(7);
         if (pick == 0)      sound = '0;
         else if (pick == 1) sound = '1;
         else                sound = vvpr_pkg::SOUND_W'($urandom_range(16'hffff));
         voice = vvpr_pkg::VOICE_W'($urandom_range(7));
         offer_request(cmd, voice, placement, sound);
      end
   endtask

   // register sets per random segment, in index order:
   // volume step, pan step, center vol, side vol, center pan, left pan, right pan
   logic [vvpr_pkg::VAL_W-1:0] segment_settings [6][REG_COUNT] = '{
      '{8'd8,   8'd2,   8'd255, 8'd100, 8'd128, 8'd60,  8'd195},
      '{8'd1,   8'd1,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255},
      '{8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0},
      '{8'd37,  8'd5,   8'd200, 8'd90,  8'd128, 8'd10,  8'd245},
      '{8'd64,  8'd128, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255},
      '{8'd3,   8'd200, 8'd17,  8'd240, 8'd1,   8'd254, 8'd128}
   };
   logic [vvpr_pkg::VAL_W-1:0] frozen_settings [REG_COUNT] =
      '{8'd0, 8'd0, 8'd255, 8'd100, 8'd128, 8'd60, 8'd195};

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on reset register values. First tick: everything at
      // rest, so the scan stops on voice 0 and only the marker comes back.
      offer_request(vvpr_pkg::CMD_TICK, 3'd0, vvpr_pkg::MODE_OTHER, 16'h0000);
      offer_request(vvpr_pkg::CMD_SOUND, 3'd0, vvpr_pkg::MODE_OTHER, 16'hffff);
      // voice with no sound
      offer_request(vvpr_pkg::CMD_SOUND, 3'd1, vvpr_pkg::MODE_OTHER, 16'h0000);
      offer_request(vvpr_pkg::CMD_SOUND, 3'd2, vvpr_pkg::MODE_OTHER, 16'h8000);
      offer_request(vvpr_pkg::CMD_SOUND, 3'd7, 3'd7,                 16'h5a5a);
      offer_request(vvpr_pkg::CMD_MODE, 3'd0, vvpr_pkg::MODE_CENTER, 16'h0000);
      offer_request(vvpr_pkg::CMD_MODE, 3'd1, vvpr_pkg::MODE_LEFT,   16'h0000);
      offer_request(vvpr_pkg::CMD_MODE, 3'd2, vvpr_pkg::MODE_RIGHT,  16'hffff);
      offer_request(vvpr_pkg::CMD_MODE, 3'd3, vvpr_pkg::MODE_CENTER, 16'h0000);
      offer_request(vvpr_pkg::CMD_MODE, 3'd4, vvpr_pkg::MODE_LEFT,   16'h0000);
      offer_request(vvpr_pkg::CMD_MODE, 3'd5, vvpr_pkg::MODE_RIGHT,  16'h0000);
      offer_request(vvpr_pkg::CMD_MODE, 3'd6, vvpr_pkg::MODE_CENTER, 16'h0000);
      offer_request(vvpr_pkg::CMD_MODE, 3'd7, 3'd7, 16'h0000);   // undefined placement
      repeat (3) offer_request(vvpr_pkg::CMD_TICK, 3'd0, vvpr_pkg::MODE_OTHER, 16'h0000);
      // voice 0 fades out and mutes; once silent the scan halts on it
      offer_request(vvpr_pkg::CMD_MODE, 3'd0, vvpr_pkg::MODE_GONE, 16'h0000);
      offer_request(CMD_UNUSED, 3'd7, 3'd7, 16'hffff);        // ignored request
      repeat (4) offer_request(vvpr_pkg::CMD_TICK, 3'd7, 3'd7, 16'hffff);
      drain_results();

      // zero steps: nothing moves yet unsettled voices report every tick
      offer_request(vvpr_pkg::CMD_MODE, 3'd0, vvpr_pkg::MODE_RIGHT, 16'h0000);
      drain_results();
      load_settings(frozen_settings);
      repeat (3) offer_request(vvpr_pkg::CMD_TICK, 3'd0, vvpr_pkg::MODE_OTHER, 16'h0000);
      drain_results();

      // Random segments: sender rarely idle and receiver often stalled,
      // then the reverse, then both flat out with one long hold-off.
      for (int seg = 0; seg < 6; seg++) begin
         if (seg < 2) begin
            req_idle_pct = 9;
            rsp_idle_pct = 56;
         end else if (seg < 4) begin
            req_idle_pct = 56;
            rsp_idle_pct = 9;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         load_settings(segment_settings[seg]);
         if (seg == 4) hold_kick <= 1'b1;
         @(posedge clock);
         hold_kick <= 1'b0;
         random_requests(SEGMENT_ITEMS);
         drain_results();
      end

      if (sb.failures == 0 && sb.pending_results.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/vvpr_pkg.sv
hdl/vvpr_ctrl.sv
hdl/vvpr_dpath.sv
hdl/voice_volume_pan_ramper.sv
test/tb_top.sv
